// ===== rtl/bpa_pkg.sv =====
`timescale 1ns / 1ps
package bpa_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_MEM    = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

  localparam logic [31:0] ADDR_NONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        op;
    logic [31:0] request_bytes;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic [1:0]  status;
    logic [2:0]  block_order;
  } res_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_WALK_RD,
    S_WALK_CHK,
    S_ALLOC_HEAD,
    S_SPLIT,
    S_FREE_CHK,
    S_BUD_RD,
    S_BUD_CHK,
    S_FREE_WR,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    RES_TOO_LARGE,
    RES_NO_MEM,
    RES_NOT_ALLOC,
    RES_ALLOC_OK,
    RES_FREE_OK
  } res_sel_e;

  typedef struct packed {
    logic     init_wr;
    logic     load;
    logic     free_idx;
    logic     alloc_start;
    logic     walk_rd;
    logic     walk_upd;
    logic     wr_head;
    logic     split_step;
    logic     free_clr;
    logic     bud_rd;
    logic     bud_merge;
    logic     free_wr;
    logic     res_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic op_free;
    logic too_large;
    logic idx_out;
    logic walk_end;
    logic walk_hit;
    logic found;
    logic split_done;
    logic free_bad;
    logic bud_out;
    logic bud_ok;
  } sts_t;

endpackage

// ===== rtl/buddy_page_allocator_core.sv =====
`timescale 1ns / 1ps
// buddy page allocator over a pool of PAGE_COUNT pages, blocks of order 0..MAX_ORDER
//
// request channel: req_i is taken at a clock edge with start high and busy low.
//   op 0 allocates request_bytes, op 1 frees the block at free_address.
// result channel: res_o is valid for the single cycle done_o is high; the
//   receiver cannot stall, so every result must be taken in that cycle.
// config: pool_base is written by cfg_we_i / cfg_wdata_i, which the user must assert
//   only while idle; the block itself leaves this to the user.
//
// sequence: allocate walks every block in address order, a memory read then a check
//   per block visited, stops early on an exact-order hit, then writes the head and
//   splits one level per step. free reads and checks one buddy per merge level.
//   one request is in flight.
// reset: the block sweeps the page table, one entry a cycle, building the initial
//   free blocks; busy stays high meanwhile.
module buddy_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int PAGE_COUNT = 1024,
  parameter int MAX_ORDER  = 6,
  parameter int PAGE_SHIFT = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output res_t        res_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  // command and status between the sequencer and the datapath
  cmd_t cmd;
  sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // page table memory, allocation walk, merge and result registers
  bpa_dpath #(
    .PAGE_COUNT (PAGE_COUNT),
    .MAX_ORDER  (MAX_ORDER),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o)
  );

  // a result only comes out while a request is in flight
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe while idle");

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request accepted but block not busy");

  // one result strobe per request
  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  // failed results carry the all-ones address
  a_fail_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != ST_OK)) |-> (res_o.block_address == ADDR_NONE))
    else $error("failed result with a block address");

endmodule

// ===== rtl/bpa_ram.sv =====
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/bpa_ctrl.sv =====
`timescale 1ns / 1ps
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = RES_NOT_ALLOC;
    case (state_q)
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.op_free) begin
          if (sts_i.idx_out) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_NOT_ALLOC;
            state_d        = S_RESP;
          end else begin
            cmd_o.free_idx = 1'b1;
            state_d        = S_FREE_CHK;
          end
        end else if (sts_i.too_large) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_TOO_LARGE;
          state_d        = S_RESP;
        end else begin
          cmd_o.alloc_start = 1'b1;
          state_d           = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (sts_i.walk_end) begin
          if (sts_i.found) begin
            state_d = S_ALLOC_HEAD;
          end else begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_NO_MEM;
            state_d        = S_RESP;
          end
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d       = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        cmd_o.walk_upd = 1'b1;
        state_d = sts_i.walk_hit ? S_ALLOC_HEAD : S_WALK_RD;
      end
      S_ALLOC_HEAD: begin
        cmd_o.wr_head = 1'b1;
        state_d       = S_SPLIT;
      end
      S_SPLIT: begin
        if (sts_i.split_done) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_ALLOC_OK;
          state_d        = S_RESP;
        end else begin
          cmd_o.split_step = 1'b1;
        end
      end
      S_FREE_CHK: begin
        if (sts_i.free_bad) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_NOT_ALLOC;
          state_d        = S_RESP;
        end else begin
          cmd_o.free_clr = 1'b1;
          state_d        = S_BUD_RD;
        end
      end
      S_BUD_RD: begin
        if (sts_i.bud_out) begin
          state_d = S_FREE_WR;
        end else begin
          cmd_o.bud_rd = 1'b1;
          state_d      = S_BUD_CHK;
        end
      end
      S_BUD_CHK: begin
        if (sts_i.bud_ok) begin
          cmd_o.bud_merge = 1'b1;
          state_d         = S_BUD_RD;
        end else begin
          state_d = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        cmd_o.free_wr  = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_FREE_OK;
        state_d        = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule

// ===== rtl/bpa_dpath.sv =====
`timescale 1ns / 1ps
module bpa_dpath
  import bpa_pkg::*;
#(
  parameter int PAGE_COUNT = 1024,
  parameter int MAX_ORDER  = 6,
  parameter int PAGE_SHIFT = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  req_t        req_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output res_t        res_o
);

  localparam int PW       = $clog2(PAGE_COUNT);
  localparam int PCW      = PW + 1;
  localparam int OW       = $clog2(MAX_ORDER + 1);
  localparam int WCW      = $clog2(MAX_ORDER + 2);
  localparam int EW       = OW + 2;
  localparam int FREE_BIT = OW + 1;
  localparam int USE_BIT  = OW;

  logic [31:0]    pool_base_q;
  req_t           req_q;
  logic [OW-1:0]  want_q;
  logic           too_large_q;
  logic [PCW-1:0] p_q;
  logic [PCW-1:0] next_head_q;
  logic [PW-1:0]  best_page_q;
  logic [OW-1:0]  best_order_q;
  logic           found_q;
  logic [PW-1:0]  idx_q;
  logic [OW-1:0]  o_q;
  res_t           res_q;

  logic           we;
  logic [PW-1:0]  waddr;
  logic [EW-1:0]  wdata;
  logic [PW-1:0]  raddr;
  logic [EW-1:0]  rdata;

  logic           rd_free;
  logic           rd_use;
  logic [OW-1:0]  rd_ord;

  logic [WCW-1:0] want_cnt;
  logic [OW-1:0]  init_ord;
  logic [31:0]    diff;
  logic [31:0]    idx_full;
  logic [31:0]    buddy32;
  logic [31:0]    upper32;
  logic [31:0]    walk_next;
  logic [OW-1:0]  h_dn;
  logic [PW-1:0]  buddy;
  logic [31:0]    best_addr;
  logic [31:0]    idx_addr;
  logic [3:0]     ord_ext;

  assign rd_free = rdata[FREE_BIT];
  assign rd_use  = rdata[USE_BIT];
  assign rd_ord  = rdata[OW-1:0];

  // order wanted: number of size thresholds the request exceeds
  always_comb begin
    want_cnt = '0;
    for (int w = 0; w <= MAX_ORDER; w++) begin
      if ({1'b0, req_i.request_bytes} > (33'd1 << (PAGE_SHIFT + w))) begin
        want_cnt = want_cnt + WCW'(1);
      end
    end
  end

  // largest aligned order that fits at the init pointer
  always_comb begin
    init_ord = '0;
    for (int o = 1; o <= MAX_ORDER; o++) begin
      if (((32'(p_q) & ((32'd1 << o) - 32'd1)) == 32'd0) &&
          (32'(p_q) + (32'd1 << o) <= 32'(PAGE_COUNT))) begin
        init_ord = OW'(o);
      end
    end
  end

  assign diff      = req_q.free_address - pool_base_q;
  assign idx_full  = diff >> PAGE_SHIFT;
  assign buddy32   = 32'(idx_q) ^ (32'd1 << o_q);
  assign buddy     = buddy32[PW-1:0];
  assign h_dn      = best_order_q - OW'(1);
  assign upper32   = 32'(best_page_q) + (32'd1 << h_dn);
  assign walk_next = 32'(p_q) + (32'd1 << rd_ord);
  assign best_addr = pool_base_q + (32'(best_page_q) << PAGE_SHIFT);
  assign idx_addr  = pool_base_q + (32'(idx_q) << PAGE_SHIFT);

  always_comb begin
    sts_o            = '0;
    sts_o.init_done  = (p_q == PCW'(PAGE_COUNT - 1));
    sts_o.op_free    = (req_q.op == OP_FREE);
    sts_o.too_large  = too_large_q;
    sts_o.idx_out    = (idx_full >= 32'(PAGE_COUNT));
    sts_o.walk_end   = (p_q >= PCW'(PAGE_COUNT));
    sts_o.walk_hit   = rd_free && (rd_ord == want_q);
    sts_o.found      = found_q;
    sts_o.split_done = (best_order_q == want_q);
    sts_o.free_bad   = !rd_use || rd_free;
    sts_o.bud_out    = (32'(o_q) >= 32'(MAX_ORDER)) || (buddy32 >= 32'(PAGE_COUNT));
    sts_o.bud_ok     = rd_free && (rd_ord == o_q);
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = '0;
    raddr = p_q[PW-1:0];
    if (cmd_i.init_wr) begin
      waddr = p_q[PW-1:0];
      if (p_q == next_head_q) begin
        we    = 1'b1;
        wdata = {1'b1, 1'b0, init_ord};
      end else begin
        we    = 1'b1;
        wdata = '0;
      end
    end else if (cmd_i.wr_head) begin
      we    = 1'b1;
      waddr = best_page_q;
      wdata = {1'b0, 1'b1, want_q};
    end else if (cmd_i.split_step) begin
      we    = (upper32 < 32'(PAGE_COUNT));
      waddr = upper32[PW-1:0];
      wdata = {1'b1, 1'b0, h_dn};
    end else if (cmd_i.free_clr) begin
      we    = 1'b1;
      wdata = {1'b0, 1'b0, rd_ord};
    end else if (cmd_i.bud_merge) begin
      we    = 1'b1;
      waddr = buddy;
      wdata = {1'b0, rd_use, rd_ord};
    end else if (cmd_i.free_wr) begin
      we    = 1'b1;
      wdata = {1'b1, 1'b0, o_q};
    end
    if (cmd_i.free_idx) begin
      raddr = idx_full[PW-1:0];
    end else if (cmd_i.bud_rd) begin
      raddr = buddy;
    end
  end

  bpa_ram #(
    .WIDTH (EW),
    .DEPTH (PAGE_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
      p_q         <= '0;
      next_head_q <= '0;
      found_q     <= 1'b0;
    end else begin
      if (cfg_we_i) pool_base_q <= cfg_wdata_i;
      if (cmd_i.init_wr) begin
        p_q <= p_q + PCW'(1);
        if (p_q == next_head_q) begin
          next_head_q <= next_head_q + PCW'(32'd1 << init_ord);
        end
      end
      if (cmd_i.alloc_start) begin
        p_q     <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.walk_upd) begin
        p_q <= walk_next[PCW-1:0];
        if (rd_free && (rd_ord >= want_q) && (!found_q || (rd_ord < best_order_q))) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q       <= req_i;
      too_large_q <= (32'(want_cnt) > 32'(MAX_ORDER));
      want_q      <= want_cnt[OW-1:0];
    end
    if (cmd_i.walk_upd && rd_free && (rd_ord >= want_q) &&
        (!found_q || (rd_ord < best_order_q))) begin
      best_page_q  <= p_q[PW-1:0];
      best_order_q <= rd_ord;
    end
    if (cmd_i.split_step) best_order_q <= h_dn;
    if (cmd_i.free_idx) idx_q <= idx_full[PW-1:0];
    if (cmd_i.free_clr) o_q <= (32'(rd_ord) > 32'(MAX_ORDER)) ? OW'(MAX_ORDER) : rd_ord;
    if (cmd_i.bud_merge) begin
      if (buddy < idx_q) idx_q <= buddy;
      o_q <= o_q + OW'(1);
    end
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        RES_TOO_LARGE: res_q <= '{ADDR_NONE, ST_TOO_LARGE, 3'd0};
        RES_NO_MEM:    res_q <= '{ADDR_NONE, ST_NO_MEM, ord_ext[2:0]};
        RES_ALLOC_OK:  res_q <= '{best_addr, ST_OK, ord_ext[2:0]};
        RES_FREE_OK:   res_q <= '{idx_addr, ST_OK, ord_ext[2:0]};
        default:       res_q <= '{ADDR_NONE, ST_NOT_ALLOC, 3'd0};
      endcase
    end
  end

  // order field of the result, low three bits
  always_comb begin
    ord_ext = 4'(want_q);
    if (cmd_i.res_sel == RES_FREE_OK) ord_ext = 4'(o_q);
  end

  assign res_o = res_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// buddy page allocator bench: a directed table, then random requests over several
// pool bases, every result checked field by field against an in-bench page model
module tb_top;
  import bpa_pkg::*;

  localparam int PAGES    = 1024;
  localparam int TOP_ORD  = 6;
  localparam int PG_SHIFT = 12;
  localparam int WD_LIMIT = 60000;  // idle cycles before the watchdog fires

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  res_t        res_o;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  always #1 clk_i = ~clk_i;

  buddy_page_allocator_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .res_o(res_o), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // page table copy kept by the bench
  logic [31:0] base_addr;
  bit          head_free [PAGES];
  logic [2:0]  head_ord  [PAGES];
  bit          head_used [PAGES];
  int          live_pages[$];  // heads of blocks currently allocated
  res_t        pending_res[$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  function automatic logic [31:0] page_addr(int p);
    return base_addr + (32'(p) << PG_SHIFT);
  endfunction

  function automatic void pool_reset();
    int p, o;
    p = 0;
    for (int i = 0; i < PAGES; i++) begin
      head_free[i] = 0; head_ord[i] = '0; head_used[i] = 0;
    end
    while (p < PAGES) begin
      o = TOP_ORD;
      while (o > 0 && ((p % (1 << o)) != 0 || p + (1 << o) > PAGES)) o--;
      head_free[p] = 1;
      head_ord[p]  = 3'(o);
      p += 1 << o;
    end
    live_pages.delete();
  endfunction

  // computes the result of one request and updates the page table copy
  function automatic res_t alloc_or_free(req_t r);
    res_t   res;
    int     want, have, pg, buddy, idx, o;
    logic [63:0] sz;
    res = '{block_address: ADDR_NONE, status: ST_OK, block_order: '0};
    if (r.op == OP_ALLOC) begin
      sz = 64'(r.request_bytes);
      want = 0;
      while (want <= TOP_ORD && sz > (64'd1 << (PG_SHIFT + want))) want++;
      if (want > TOP_ORD) begin
        res.status = ST_TOO_LARGE;
        return res;
      end
      pg = PAGES;
      for (have = want; have <= TOP_ORD && pg == PAGES; have++)
        for (int p = 0; p < PAGES; p++)
          if (head_free[p] && head_ord[p] == 3'(have)) begin
            pg = p;
            break;
          end
      if (pg == PAGES) begin
        res.status = ST_NO_MEM;
        res.block_order = 3'(want);
        return res;
      end
      have--;  // loop stepped one past the hit
      head_free[pg] = 0;
      while (have > want) begin
        have--;
        if (pg + (1 << have) < PAGES) begin
          head_free[pg + (1 << have)] = 1;
          head_ord[pg + (1 << have)]  = 3'(have);
          head_used[pg + (1 << have)] = 0;
        end
      end
      head_ord[pg] = 3'(want);
      head_used[pg] = 1;
      live_pages.push_back(pg);
      res.block_address = page_addr(pg);
      res.block_order = 3'(want);
    end else begin
      idx = int'((r.free_address - base_addr) >> PG_SHIFT);
      if ((r.free_address - base_addr) >> PG_SHIFT >= PAGES || !head_used[idx]
          || head_free[idx]) begin
        res.status = ST_NOT_ALLOC;
        return res;
      end
      foreach (live_pages[i])
        if (live_pages[i] == idx) begin
          live_pages.delete(i);
          break;
        end
      head_used[idx] = 0;
      o = head_ord[idx];
      if (o > TOP_ORD) o = TOP_ORD;
      while (o < TOP_ORD) begin
        buddy = idx ^ (1 << o);
        if (buddy >= PAGES || !head_free[buddy] || head_ord[buddy] != 3'(o)) break;
        head_free[buddy] = 0;
        if (buddy < idx) idx = buddy;
        o++;
      end
      head_free[idx] = 1;
      head_ord[idx]  = 3'(o);
      head_used[idx] = 0;
      res.block_address = page_addr(idx);
      res.block_order = 3'(o);
    end
    return res;
  endfunction

  function automatic req_t mk_req(logic op, logic [31:0] bytes, logic [31:0] addr);
    req_t r;
    r.op = op; r.request_bytes = bytes; r.free_address = addr;
    return r;
  endfunction

  // result checker: the receiver never stalls, so compare every done cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_o);
      end else begin
        if (res_o !== pending_res[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp addr %h st %0d ord %0d, got addr %h st %0d ord %0d",
                     pending_res[0].block_address, pending_res[0].status,
                     pending_res[0].block_order, res_o.block_address, res_o.status,
                     res_o.block_order);
        end
        void'(pending_res.pop_front());
      end
    end
  end

  // watchdog: counts cycles with no request taken and no result returned
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  int burst_left = 0;

  // drives one request and holds it until taken; start is left high
  task automatic send_req(req_t r, bit chk, res_t golden);
    res_t pred;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 25);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pred = alloc_or_free(r);
    if (chk && pred !== golden) begin
      mismatches++;
      if (mismatches <= 10) $display("directed row expectation %p vs model %p", golden, pred);
    end
    pending_res.push_back(pred);
  endtask

  // drains outstanding results, then writes the pool base while idle
  task automatic set_pool_base(logic [31:0] b);
    start <= 1'b0;
    burst_left = 0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    base_addr = b;
  endtask

  // random request: mostly well formed allocate / free traffic, some noise
  function automatic req_t rand_req(bit big);
    int pick, k;
    logic [31:0] off;
    pick = $urandom_range(0, 99);
    off = 32'($urandom_range(0, (1 << PG_SHIFT) - 1));
    if (pick < 55) begin
      if ($urandom_range(0, 19) == 0) return mk_req(OP_ALLOC, $urandom, $urandom);
      if (big) return mk_req(OP_ALLOC, $urandom_range(60000, 262144), $urandom);
      return mk_req(OP_ALLOC, $urandom_range(0, 20000), $urandom);
    end
    if (pick < 90 && live_pages.size() != 0) begin
      k = $urandom_range(0, live_pages.size() - 1);
      return mk_req(OP_FREE, $urandom, page_addr(live_pages[k]) + off);
    end
    if (pick < 95) return mk_req(OP_FREE, $urandom, page_addr($urandom_range(0, PAGES + 8)) + off);
    return mk_req(OP_FREE, $urandom, $urandom);
  endfunction

  typedef struct {
    req_t r;
    bit   chk;
    res_t e;
  } row_t;

  row_t rows[$];

  function automatic void add_row(req_t r, bit chk, logic [31:0] a, logic [1:0] s,
                                  logic [2:0] o);
    row_t w;
    w.r = r; w.chk = chk;
    w.e = '{block_address: a, status: s, block_order: o};
    rows.push_back(w);
  endfunction

  initial begin
    base_addr = '0;
    pool_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);  // initial sweep of the page table

    set_pool_base(32'h0);
    // directed rows, pool base 0
    add_row(mk_req(OP_ALLOC, 32'd0, '1), 1, 32'h0, ST_OK, 3'd0);            // zero size
    add_row(mk_req(OP_ALLOC, 32'hFFFF_FFFF, '0), 1, ADDR_NONE, ST_TOO_LARGE, 3'd0);
    add_row(mk_req(OP_ALLOC, 32'd262144, '0), 1, 32'h0004_0000, ST_OK, 3'd6);
    add_row(mk_req(OP_ALLOC, 32'd262145, '0), 1, ADDR_NONE, ST_TOO_LARGE, 3'd0);
    add_row(mk_req(OP_FREE, '0, 32'h0000_1000), 1, ADDR_NONE, ST_NOT_ALLOC, 3'd0);
    add_row(mk_req(OP_FREE, '1, 32'hFFFF_FFFF), 1, ADDR_NONE, ST_NOT_ALLOC, 3'd0);
    add_row(mk_req(OP_FREE, '0, 32'h0000_0FFF), 1, 32'h0, ST_OK, 3'd6);     // offset ignored
    add_row(mk_req(OP_FREE, '0, 32'h0000_0000), 1, ADDR_NONE, ST_NOT_ALLOC, 3'd0);
    add_row(mk_req(OP_FREE, '0, 32'h0040_0000), 1, ADDR_NONE, ST_NOT_ALLOC, 3'd0);
    add_row(mk_req(OP_ALLOC, 32'd4097, '0), 0, '0, '0, '0);
    add_row(mk_req(OP_ALLOC, 32'd4096, '0), 0, '0, '0, '0);
    add_row(mk_req(OP_ALLOC, 32'd1, '0), 0, '0, '0, '0);
    add_row(mk_req(OP_ALLOC, 32'd131072, '0), 0, '0, '0, '0);
    add_row(mk_req(OP_ALLOC, 32'd16385, '0), 0, '0, '0, '0);
    add_row(mk_req(OP_FREE, '0, 32'h0000_2000), 0, '0, '0, '0);
    add_row(mk_req(OP_FREE, '0, 32'h0000_0000), 0, '0, '0, '0);
    add_row(mk_req(OP_FREE, '0, 32'h0000_1ABC), 0, '0, '0, '0);
    add_row(mk_req(OP_FREE, '0, 32'h0003_F000), 0, '0, '0, '0);            // last page of the first order-6 block
    foreach (rows[i]) send_req(rows[i].r, rows[i].chk, rows[i].e);

    // random phases over several pool bases, the extremes among them
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_pool_base(32'hFFFF_F000);  // block addresses wrap
        1: set_pool_base(32'h1234_5678);
        2: set_pool_base(32'hFFFF_FFFF);
        default: set_pool_base($urandom);
      endcase
      for (int n = 0; n < 160; n++) begin
        req_t r;
        r = rand_req(ph == 1 || ph == 3);
        send_req(r, 0, '0);
      end
    end
    start <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_ctrl.sv
rtl/bpa_dpath.sv
rtl/buddy_page_allocator_core.sv
bench/tb_top.sv
